// File: rtl/idw_pkg.sv
// Shared types and constants for the integer divider with remainder.
// No dependencies; used by int_divide_with_remainder and its testbench.
package idw_pkg;

    localparam int FIELD_WIDTH  = 64;
    localparam int NARROW_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS_N,
        ST_ABS_D,
        ST_DIV,
        ST_FIX_Q,
        ST_FIX_R
    } idw_state_t;

endpackage

// File: rtl/idw_sub.sv
// Shared subtractor of the divider: difference and borrow of two operands.
// Depends on nothing; instantiated once by int_divide_with_remainder.
module idw_sub #(
    parameter int WIDTH = 65
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             borrow
);

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// File: rtl/int_divide_with_remainder.sv
// Signed/unsigned integer divider with remainder, 32-bit or DATA_WIDTH-bit words.
// Uses idw_pkg and one idw_sub, a shared subtractor under a small sequencer.
// Steps: the accepting edge loads the operands, then ST_ABS_N and ST_ABS_D take
// absolute values on the subtractor, ST_DIV does one restoring step per quotient
// bit (W = 32 when narrow, else DATA_WIDTH), ST_FIX_Q and ST_FIX_R fix the signs,
// and done is registered out of ST_FIX_R; a zero divisor answers straight from idle.
// A new item is taken only in the idle state, after the previous one is done.
// Reset clears the sequencer and the done strobe; results cannot be stalled.
module int_divide_with_remainder #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic                          narrow,
    input  logic [idw_pkg::FIELD_WIDTH-1:0] dividend,
    input  logic [idw_pkg::FIELD_WIDTH-1:0] divisor,
    output logic                          done,
    output logic [idw_pkg::FIELD_WIDTH-1:0] quotient,
    output logic [idw_pkg::FIELD_WIDTH-1:0] remainder,
    output logic                          divide_by_zero
);

    import idw_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);
    localparam logic [DATA_WIDTH-1:0] NARROW_MASK =
        DATA_WIDTH'((65'd1 << NARROW_WIDTH) - 65'd1);
    localparam logic [DATA_WIDTH-1:0] FULL_MASK = '1;

    idw_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0]   num_reg, num_next;
    logic [DATA_WIDTH-1:0]   den_reg, den_next;
    logic [DATA_WIDTH-1:0]   rem_reg, rem_next;
    logic                    narrow_reg, narrow_next;
    logic                    nneg_reg, nneg_next;
    logic                    dneg_reg, dneg_next;
    logic [DATA_WIDTH-1:0]   quo_out_reg, quo_out_next;
    logic [DATA_WIDTH-1:0]   rem_out_reg, rem_out_next;
    logic                    dz_out_reg, dz_out_next;
    logic                    done_reg, done_next;

    logic [DATA_WIDTH:0]     alu_a, alu_b, alu_diff;
    logic                    alu_borrow;
    logic [DATA_WIDTH-1:0]   alu_neg;
    logic [DATA_WIDTH-1:0]   mask_work;
    logic [DATA_WIDTH-1:0]   in_mask;
    logic [DATA_WIDTH-1:0]   in_n, in_d;
    logic                    in_nsign, in_dsign;

    idw_sub #(
        .WIDTH (DATA_WIDTH + 1)
    ) u_sub (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    assign mask_work = narrow_reg ? NARROW_MASK : FULL_MASK;
    assign alu_neg   = alu_diff[DATA_WIDTH-1:0] & mask_work;

    assign in_mask  = narrow ? NARROW_MASK : FULL_MASK;
    assign in_n     = dividend[DATA_WIDTH-1:0] & in_mask;
    assign in_d     = divisor[DATA_WIDTH-1:0] & in_mask;
    assign in_nsign = narrow ? dividend[NARROW_WIDTH-1] : dividend[DATA_WIDTH-1];
    assign in_dsign = narrow ? divisor[NARROW_WIDTH-1] : divisor[DATA_WIDTH-1];

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign quotient       = FIELD_WIDTH'(quo_out_reg);
    assign remainder      = FIELD_WIDTH'(rem_out_reg);
    assign divide_by_zero = dz_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        narrow_reg  <= narrow_next;
        nneg_reg    <= nneg_next;
        dneg_reg    <= dneg_next;
        quo_out_reg <= quo_out_next;
        rem_out_reg <= rem_out_next;
        dz_out_reg  <= dz_out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        narrow_next  = narrow_reg;
        nneg_next    = nneg_reg;
        dneg_next    = dneg_reg;
        quo_out_next = quo_out_reg;
        rem_out_next = rem_out_reg;
        dz_out_next  = dz_out_reg;
        done_next    = 1'b0;
        alu_a        = '0;
        alu_b        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (in_d == '0)
                    begin
                        quo_out_next = in_mask;
                        rem_out_next = in_n;
                        dz_out_next  = 1'b1;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        num_next    = in_n;
                        den_next    = in_d;
                        narrow_next = narrow;
                        nneg_next   = operation & in_nsign;
                        dneg_next   = operation & in_dsign;
                        state_next  = ST_ABS_N;
                    end
                end
            end
            ST_ABS_N:
            begin
                alu_b = {1'b0, num_reg};
                if (nneg_reg)
                begin
                    num_next = alu_neg;
                end
                state_next = ST_ABS_D;
            end
            ST_ABS_D:
            begin
                alu_b = {1'b0, den_reg};
                if (dneg_reg)
                begin
                    den_next = alu_neg;
                end
                // align the dividend's top bit with the word's top bit
                if (narrow_reg)
                begin
                    num_next = num_reg << (DATA_WIDTH - NARROW_WIDTH);
                end
                rem_next   = '0;
                cnt_next   = narrow_reg ? CNT_W'(NARROW_WIDTH) : CNT_W'(DATA_WIDTH);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                alu_a = {rem_reg, num_reg[DATA_WIDTH-1]};
                alu_b = {1'b0, den_reg};
                rem_next = alu_borrow ? alu_a[DATA_WIDTH-1:0] : alu_diff[DATA_WIDTH-1:0];
                num_next = {num_reg[DATA_WIDTH-2:0], ~alu_borrow};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FIX_Q;
                end
            end
            ST_FIX_Q:
            begin
                alu_b = {1'b0, num_reg};
                if (nneg_reg != dneg_reg)
                begin
                    num_next = alu_neg;
                end
                state_next = ST_FIX_R;
            end
            ST_FIX_R:
            begin
                alu_b        = {1'b0, rem_reg};
                quo_out_next = num_reg;
                rem_out_next = nneg_reg ? alu_neg : rem_reg;
                dz_out_next  = 1'b0;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: tb/int_divide_with_remainder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for int_divide_with_remainder: directed table, then random beats.
// Depends on idw_pkg and the int_divide_with_remainder RTL; checks every done strobe.
module int_divide_with_remainder_tb;

    localparam int FW          = idw_pkg::FIELD_WIDTH;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BEATS = 700;
    localparam int DRAIN_CYCLES = 80;
    localparam int N_DIRECTED  = 24;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;
    localparam logic WORD_64     = 1'b0;
    localparam logic WORD_32     = 1'b1;

    localparam logic [FW-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [FW-1:0] MIN_64   = 64'h8000_0000_0000_0000;
    localparam logic [FW-1:0] MAX_64   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [FW-1:0] quo;
        logic [FW-1:0] rem;
        logic          dbz;
    } div_result_t;

    typedef struct packed {
        logic          op;
        logic          nar;
        logic [FW-1:0] num;
        logic [FW-1:0] den;
        logic          known;
        logic [FW-1:0] quo;
        logic [FW-1:0] rem;
        logic          dbz;
    } div_case_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic          operation = 1'b0;
    logic          narrow = 1'b0;
    logic [FW-1:0] dividend = '0;
    logic [FW-1:0] divisor = '0;
    logic          done;
    logic [FW-1:0] quotient;
    logic [FW-1:0] remainder;
    logic          divide_by_zero;

    div_result_t   quotients_due[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;

    div_case_t directed_cases [N_DIRECTED] = '{
        '{OP_UNSIGNED, WORD_64, 64'd100, 64'd7, 1'b1, 64'd14, 64'd2, 1'b0},
        '{OP_UNSIGNED, WORD_64, 64'h0123_4567_89AB_CDEF, 64'd0, 1'b1,
          ALL_ONES, 64'h0123_4567_89AB_CDEF, 1'b1},
        '{OP_SIGNED, WORD_32, 64'hFEDC_BA98_7654_3210, 64'hFFFF_FFFF_0000_0000, 1'b1,
          64'h0000_0000_FFFF_FFFF, 64'h0000_0000_7654_3210, 1'b1},
        '{OP_SIGNED, WORD_64, MIN_64, ALL_ONES, 1'b1, MIN_64, 64'd0, 1'b0},
        '{OP_SIGNED, WORD_32, 64'hDEAD_BEEF_8000_0000, 64'h1234_5678_FFFF_FFFF, 1'b1,
          64'h0000_0000_8000_0000, 64'd0, 1'b0},
        '{OP_UNSIGNED, WORD_64, ALL_ONES, ALL_ONES, 1'b1, 64'd1, 64'd0, 1'b0},
        '{OP_UNSIGNED, WORD_64, ALL_ONES, 64'd1, 1'b1, ALL_ONES, 64'd0, 1'b0},
        '{OP_UNSIGNED, WORD_32, 64'hA5A5_A5A5_FFFF_FFFF, 64'h5A5A_5A5A_0000_0001, 1'b1,
          64'h0000_0000_FFFF_FFFF, 64'd0, 1'b0},
        '{OP_UNSIGNED, WORD_64, 64'd0, ALL_ONES, 1'b1, 64'd0, 64'd0, 1'b0},
        '{OP_UNSIGNED, WORD_64, 64'd1, ALL_ONES, 1'b1, 64'd0, 64'd1, 1'b0},
        '{OP_SIGNED, WORD_64, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 1'b1,
          64'hFFFF_FFFF_FFFF_FFFD, ALL_ONES, 1'b0},
        '{OP_SIGNED, WORD_64, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
          64'hFFFF_FFFF_FFFF_FFFD, 64'd1, 1'b0},
        '{OP_SIGNED, WORD_64, 64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
          64'd3, ALL_ONES, 1'b0},
        '{OP_SIGNED, WORD_32, 64'h0000_0000_FFFF_FFF9, 64'h7777_7777_0000_0002, 1'b1,
          64'h0000_0000_FFFF_FFFD, 64'h0000_0000_FFFF_FFFF, 1'b0},
        '{OP_SIGNED, WORD_64, MIN_64, 64'd1, 1'b1, MIN_64, 64'd0, 1'b0},
        '{OP_SIGNED, WORD_64, MAX_64, MIN_64, 1'b0, 64'd0, 64'd0, 1'b0},
        '{OP_SIGNED, WORD_64, MIN_64, MIN_64, 1'b0, 64'd0, 64'd0, 1'b0},
        '{OP_UNSIGNED, WORD_64, MIN_64, 64'd3, 1'b0, 64'd0, 64'd0, 1'b0},
        '{OP_UNSIGNED, WORD_64, ALL_ONES, 64'h8000_0000_0000_0001, 1'b0,
          64'd0, 64'd0, 1'b0},
        '{OP_SIGNED, WORD_64, 64'hFFFF_FFFF_FFFF_FF00, 64'd0, 1'b1,
          ALL_ONES, 64'hFFFF_FFFF_FFFF_FF00, 1'b1},
        '{OP_UNSIGNED, WORD_32, 64'h1111_1111_FFFF_FFFF, 64'h2222_2222_FFFF_FFFF, 1'b1,
          64'd1, 64'd0, 1'b0},
        '{OP_SIGNED, WORD_32, 64'h0000_0000_8000_0000, 64'd1, 1'b1,
          64'h0000_0000_8000_0000, 64'd0, 1'b0},
        '{OP_SIGNED, WORD_32, 64'hCAFE_0000_8765_4321, 64'd19, 1'b0, 64'd0, 64'd0, 1'b0},
        '{OP_UNSIGNED, WORD_32, 64'd5, 64'h0000_0000_8000_0000, 1'b0, 64'd0, 64'd0, 1'b0}
    };

    int_divide_with_remainder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .narrow         (narrow),
        .dividend       (dividend),
        .divisor        (divisor),
        .done           (done),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero)
    );

    always #4 clk = ~clk;

    function automatic div_result_t divide_words(input logic is_signed, input logic nar,
                                                 input logic [FW-1:0] num_in,
                                                 input logic [FW-1:0] den_in);
        logic [FW-1:0] mask;
        logic [FW-1:0] sign_bit;
        logic [FW-1:0] num;
        logic [FW-1:0] den;
        logic [FW-1:0] abs_num;
        logic [FW-1:0] abs_den;
        logic [FW-1:0] quo;
        logic [FW-1:0] rem;
        logic          num_neg;
        logic          den_neg;
        div_result_t   res;
        mask     = nar ? 64'h0000_0000_FFFF_FFFF : ALL_ONES;
        sign_bit = nar ? 64'h0000_0000_8000_0000 : MIN_64;
        num      = num_in & mask;
        den      = den_in & mask;
        if (den == '0)
        begin
            res.quo = mask;
            res.rem = num;
            res.dbz = 1'b1;
            return res;
        end
        num_neg = is_signed && ((num & sign_bit) != '0);
        den_neg = is_signed && ((den & sign_bit) != '0);
        abs_num = num_neg ? ((-num) & mask) : num;
        abs_den = den_neg ? ((-den) & mask) : den;
        quo = abs_num / abs_den;
        rem = abs_num % abs_den;
        if (num_neg != den_neg)
            quo = -quo;
        if (num_neg)
            rem = -rem;
        res.quo = quo & mask;
        res.rem = rem & mask;
        res.dbz = 1'b0;
        return res;
    endfunction

    function automatic logic [FW-1:0] pick_operand(input logic nar);
        logic [FW-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0: v = FW'($urandom_range(15));
            1: v = ALL_ONES;
            2: v = nar ? {v[63:32], 32'h8000_0000} : MIN_64;
            3: v = nar ? {v[63:32], 32'h7FFF_FFFF} : MAX_64;
            4: v = -FW'($urandom_range(1, 15));
            5: v = v >> $urandom_range(63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic issue_division(input logic op, input logic nar, input logic [FW-1:0] num,
                                  input logic [FW-1:0] den, input div_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        narrow    <= nar;
        dividend  <= num;
        divisor   <= den;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        quotients_due.push_back(want);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        div_result_t want;
        if (rst_n && done)
        begin
            if (quotients_due.size() == 0)
            begin
                $error("unexpected result beat: quotient %h remainder %h", quotient, remainder);
                fail_count++;
            end
            else
            begin
                want = quotients_due.pop_front();
                if (quotient !== want.quo)
                begin
                    $error("quotient: expected %h, actual %h", want.quo, quotient);
                    fail_count++;
                end
                if (remainder !== want.rem)
                begin
                    $error("remainder: expected %h, actual %h", want.rem, remainder);
                    fail_count++;
                end
                if (divide_by_zero !== want.dbz)
                begin
                    $error("divide_by_zero: expected %b, actual %b", want.dbz, divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        div_result_t   want;
        logic          op;
        logic          nar;
        logic [FW-1:0] num;
        logic [FW-1:0] den;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
        begin
            if (directed_cases[i].known)
            begin
                want.quo = directed_cases[i].quo;
                want.rem = directed_cases[i].rem;
                want.dbz = directed_cases[i].dbz;
            end
            else
                want = divide_words(directed_cases[i].op, directed_cases[i].nar,
                                    directed_cases[i].num, directed_cases[i].den);
            issue_division(directed_cases[i].op, directed_cases[i].nar,
                           directed_cases[i].num, directed_cases[i].den, want);
        end

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            case (i * 3 / RANDOM_BEATS)
                0: send_idle_pct = 0;
                1: send_idle_pct = 73;
                default: send_idle_pct = 38;
            endcase
            op  = $urandom_range(1) ? OP_SIGNED : OP_UNSIGNED;
            nar = $urandom_range(1) ? WORD_32 : WORD_64;
            num = pick_operand(nar);
            den = pick_operand(nar);
            // zero divisor, with junk above the word when narrow
            if ($urandom_range(99) < 4)
                den = nar ? {den[63:32], 32'h0} : '0;
            issue_division(op, nar, num, den, divide_words(op, nar, num, den));
        end
        start <= 1'b0;

        while (quotients_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
